// ===== hw/rtl/alsc_pkg.sv =====
// Shared types and constants for the area light sample contribution block.
// Used by the channel interfaces and every RTL module; depends on nothing.
package alsc_pkg;

    // Datapath sizes
    localparam int SQRT_STAGES = 32;             // one root bit per stage
    localparam int QUO_W       = 32;             // quotient bits per divide
    localparam int DIV_LAT     = QUO_W + 1;      // range check plus one stage per bit
    localparam int NUM_W       = 96;             // dividend width
    localparam int DEN_W       = 64;             // divisor width
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X   = 3'd0,
        CFG_NORMAL_Y   = 3'd1,
        CFG_NORMAL_Z   = 3'd2,
        CFG_AREA       = 3'd3,
        CFG_RADIANCE_R = 3'd4,
        CFG_RADIANCE_G = 3'd5,
        CFG_RADIANCE_B = 3'd6
    } t_cfg_idx;

    // Configuration reset values
    localparam logic signed [15:0] NORMAL_X_RST   = 16'sd0;
    localparam logic signed [15:0] NORMAL_Y_RST   = 16'sd0;
    localparam logic signed [15:0] NORMAL_Z_RST   = 16'sd16384;
    localparam logic [31:0]        AREA_RST       = 32'd65536;
    localparam logic [15:0]        RADIANCE_RST   = 16'd256;

    // Input item
    typedef struct packed {
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic signed [15:0] surface_normal_x;
        logic signed [15:0] surface_normal_y;
        logic signed [15:0] surface_normal_z;
        logic signed [31:0] light_x;
        logic signed [31:0] light_y;
        logic signed [31:0] light_z;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [31:0] contrib_red;
        logic [31:0] contrib_green;
        logic [31:0] contrib_blue;
        logic [31:0] sample_pdf;
        logic        sample_valid;
    } t_out_item;

    // Geometry handed from the front end to the square root
    typedef struct packed {
        logic        rej;    // zero squared distance or back facing at either end
        logic [63:0] d2;     // squared distance, Q34.30
        logic [62:0] num_a;  // (n . d) << 13, zero when rejected
        logic [62:0] num_b;  // -(nl . d) << 13, zero when rejected
    } t_geo;

endpackage

// ===== hw/rtl/alsc_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// Depends on alsc_pkg for the payload types.
interface alsc_in_if;
    import alsc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface alsc_out_if;
    import alsc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/area_light_sample_contribution_top.sv =====
// Area light sample contribution top level: config registers and full pipeline.
// Pipeline from input accept to result valid: front end, square root, cosine divides,
// shading products, final divides, output register.
// Throughput one item per cycle; the whole pipeline holds while the result waits.
// Synchronous active-low reset clears valid bits and loads config reset values.
// Depends on alsc_pkg, alsc_if, alsc_front, alsc_sqrt, alsc_div and alsc_post.
module area_light_sample_contribution_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    alsc_in_if.sink                         i_in,
    alsc_out_if.source                      o_out,
    input  logic                            i_cfg_wr_en,
    input  logic [alsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import alsc_pkg::*;

    // configuration
    logic signed [15:0] r_nl_x;
    logic signed [15:0] r_nl_y;
    logic signed [15:0] r_nl_z;
    logic [31:0]        r_area;
    logic [15:0]        r_rad_r;
    logic [15:0]        r_rad_g;
    logic [15:0]        r_rad_b;

    logic               w_en;
    logic               fe_vld;
    t_geo               fe_geo;
    logic               sq_vld;
    t_geo               sq_geo;
    logic [31:0]        sq_dist;
    logic [31:0]        w_cx;
    logic [31:0]        w_cy;

    logic [DIV_LAT-1:0] r_dl1_vld;
    logic [DIV_LAT-1:0] r_dl1_rej;
    logic [63:0]        r_dl1_d2 [DIV_LAT];

    logic               pp_vld;
    logic               pp_rej;
    logic [63:0]        pp_d2;
    logic [NUM_W-1:0]   pp_pdf_num;
    logic [DEN_W-1:0]   pp_pdf_den;
    logic [NUM_W-1:0]   pp_red_num;
    logic [NUM_W-1:0]   pp_green_num;
    logic [NUM_W-1:0]   pp_blue_num;

    logic [DIV_LAT-1:0] r_dl2_vld;
    logic [DIV_LAT-1:0] r_dl2_rej;
    logic [31:0]        w_pdf;
    logic [31:0]        w_red;
    logic [31:0]        w_green;
    logic [31:0]        w_blue;

    logic               r_out_vld;
    t_out_item          r_out;
    t_out_item          n_out;

    // global advance: move when the output register is free or being taken
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_x  <= NORMAL_X_RST;
            r_nl_y  <= NORMAL_Y_RST;
            r_nl_z  <= NORMAL_Z_RST;
            r_area  <= AREA_RST;
            r_rad_r <= RADIANCE_RST;
            r_rad_g <= RADIANCE_RST;
            r_rad_b <= RADIANCE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NORMAL_X:   r_nl_x  <= i_cfg_data[15:0];
                CFG_NORMAL_Y:   r_nl_y  <= i_cfg_data[15:0];
                CFG_NORMAL_Z:   r_nl_z  <= i_cfg_data[15:0];
                CFG_AREA:       r_area  <= i_cfg_data[31:0];
                CFG_RADIANCE_R: r_rad_r <= i_cfg_data[15:0];
                CFG_RADIANCE_G: r_rad_g <= i_cfg_data[15:0];
                CFG_RADIANCE_B: r_rad_b <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    alsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_item  (i_in.payload),
        .i_nl_x  (r_nl_x),
        .i_nl_y  (r_nl_y),
        .i_nl_z  (r_nl_z),
        .o_vld   (fe_vld),
        .o_geo   (fe_geo)
    );

    alsc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (fe_vld),
        .i_geo   (fe_geo),
        .o_vld   (sq_vld),
        .o_geo   (sq_geo),
        .o_dist  (sq_dist)
    );

    // cosines: quotients stay below 2^31 for any accepted sample
    alsc_div u_div_cx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({33'b0, sq_geo.num_a}),
        .i_den ({32'b0, sq_dist}),
        .o_quo (w_cx)
    );

    alsc_div u_div_cy (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({33'b0, sq_geo.num_b}),
        .i_den ({32'b0, sq_dist}),
        .o_quo (w_cy)
    );

    // side data alongside the cosine divides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl1_vld <= '0;
        end else if (w_en) begin
            r_dl1_vld <= {r_dl1_vld[DIV_LAT-2:0], sq_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl1_rej   <= {r_dl1_rej[DIV_LAT-2:0], sq_geo.rej};
            r_dl1_d2[0] <= sq_geo.d2;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dl1_d2[i] <= r_dl1_d2[i-1];
            end
        end
    end

    alsc_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (r_dl1_vld[DIV_LAT-1]),
        .i_rej       (r_dl1_rej[DIV_LAT-1]),
        .i_d2        (r_dl1_d2[DIV_LAT-1]),
        .i_cx        (w_cx),
        .i_cy        (w_cy),
        .i_area      (r_area),
        .i_rad_r     (r_rad_r),
        .i_rad_g     (r_rad_g),
        .i_rad_b     (r_rad_b),
        .o_vld       (pp_vld),
        .o_rej       (pp_rej),
        .o_d2        (pp_d2),
        .o_pdf_num   (pp_pdf_num),
        .o_pdf_den   (pp_pdf_den),
        .o_red_num   (pp_red_num),
        .o_green_num (pp_green_num),
        .o_blue_num  (pp_blue_num)
    );

    alsc_div u_div_pdf (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (pp_pdf_num),
        .i_den (pp_pdf_den),
        .o_quo (w_pdf)
    );

    alsc_div u_div_red (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (pp_red_num),
        .i_den (pp_d2),
        .o_quo (w_red)
    );

    alsc_div u_div_green (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (pp_green_num),
        .i_den (pp_d2),
        .o_quo (w_green)
    );

    alsc_div u_div_blue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (pp_blue_num),
        .i_den (pp_d2),
        .o_quo (w_blue)
    );

    // side data alongside the final divides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl2_vld <= '0;
        end else if (w_en) begin
            r_dl2_vld <= {r_dl2_vld[DIV_LAT-2:0], pp_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl2_rej <= {r_dl2_rej[DIV_LAT-2:0], pp_rej};
        end
    end

    // rejected samples come out black with pdf 0
    always_comb begin
        if (r_dl2_rej[DIV_LAT-1]) begin
            n_out = '0;
        end else begin
            n_out.contrib_red   = w_red;
            n_out.contrib_green = w_green;
            n_out.contrib_blue  = w_blue;
            n_out.sample_pdf    = w_pdf;
            n_out.sample_valid  = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dl2_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

endmodule

// ===== hw/rtl/alsc_front.sv =====
// Front end: direction to the light, squared length, both dot products, reject.
// Four register stages; depends on alsc_pkg.
module alsc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  alsc_pkg::t_in_item i_item,
    input  logic signed [15:0] i_nl_x,
    input  logic signed [15:0] i_nl_y,
    input  logic signed [15:0] i_nl_z,
    output logic               o_vld,
    output alsc_pkg::t_geo     o_geo
);
    import alsc_pkg::*;

    // stage 1: difference vector
    logic signed [32:0] r1_d [3];
    logic signed [32:0] n1_d [3];
    logic signed [15:0] r1_n [3];
    logic               r1_vld;

    // stage 2: squares and products
    logic [31:0]        w_mag [3];
    logic [63:0]        r2_sq [3];
    logic [63:0]        n2_sq [3];
    logic signed [48:0] r2_pa [3];
    logic signed [48:0] n2_pa [3];
    logic signed [48:0] r2_pb [3];
    logic signed [48:0] n2_pb [3];
    logic signed [15:0] w_nl  [3];
    logic               r2_vld;

    // stage 3: sums
    logic [65:0]        w_sum;
    logic [63:0]        r3_d2;
    logic signed [50:0] r3_a;
    logic signed [50:0] n3_a;
    logic signed [50:0] r3_b;
    logic signed [50:0] n3_b;
    logic               r3_vld;

    // stage 4: reject and dividends
    t_geo               r4_geo;
    t_geo               n4_geo;
    logic               r4_vld;

    assign w_nl[0] = i_nl_x;
    assign w_nl[1] = i_nl_y;
    assign w_nl[2] = i_nl_z;

    always_comb begin
        n1_d[0] = 33'(i_item.light_x) - 33'(i_item.hit_x);
        n1_d[1] = 33'(i_item.light_y) - 33'(i_item.hit_y);
        n1_d[2] = 33'(i_item.light_z) - 33'(i_item.hit_z);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r1_d[k][32] ? 32'(-r1_d[k]) : r1_d[k][31:0];
            n2_sq[k] = 64'(w_mag[k]) * 64'(w_mag[k]);
            n2_pa[k] = r1_n[k] * r1_d[k];
            n2_pb[k] = w_nl[k] * r1_d[k];
        end
    end

    always_comb begin
        w_sum = 66'(r2_sq[0]) + 66'(r2_sq[1]) + 66'(r2_sq[2]);
        n3_a  = 51'(r2_pa[0]) + 51'(r2_pa[1]) + 51'(r2_pa[2]);
        n3_b  = -(51'(r2_pb[0]) + 51'(r2_pb[1]) + 51'(r2_pb[2]));
    end

    // both dot products are below 2^49 when positive
    always_comb begin
        n4_geo.rej   = (r3_d2 == '0) || (r3_a <= 0) || (r3_b <= 0);
        n4_geo.d2    = r3_d2;
        n4_geo.num_a = n4_geo.rej ? '0 : {r3_a[49:0], 13'b0};
        n4_geo.num_b = n4_geo.rej ? '0 : {r3_b[49:0], 13'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= n1_d;
            r1_n[0] <= i_item.surface_normal_x;
            r1_n[1] <= i_item.surface_normal_y;
            r1_n[2] <= i_item.surface_normal_z;
            r2_sq   <= n2_sq;
            r2_pa   <= n2_pa;
            r2_pb   <= n2_pb;
            r3_d2   <= w_sum[65:2];
            r3_a    <= n3_a;
            r3_b    <= n3_b;
            r4_geo  <= n4_geo;
        end
    end

    assign o_vld = r4_vld;
    assign o_geo = r4_geo;

endmodule

// ===== hw/rtl/alsc_sqrt.sv =====
// Pipelined integer square root of the squared distance, one root bit per stage.
// Carries the geometry alongside; depends on alsc_pkg.
module alsc_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  alsc_pkg::t_geo i_geo,
    output logic           o_vld,
    output alsc_pkg::t_geo o_geo,
    output logic [31:0]    o_dist
);
    import alsc_pkg::*;

    logic [33:0] r_rem  [SQRT_STAGES];
    logic [31:0] r_root [SQRT_STAGES];
    t_geo        r_geo  [SQRT_STAGES];
    logic        r_vld  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [33:0] w_rem_in;
        logic [31:0] w_root_in;
        t_geo        w_geo_in;
        logic        w_vld_in;
        logic [35:0] w_trem;
        logic [35:0] w_trial;
        logic        w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_geo_in  = i_geo;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_geo_in  = r_geo[s-1];
            assign w_vld_in  = r_vld[s-1];
        end

        // bring down the next pair of bits and try (root << 2) | 1
        assign w_trem  = {w_rem_in, w_geo_in.d2[2*(SQRT_STAGES-1-s) +: 2]};
        assign w_trial = {2'b0, w_root_in, 2'b01};
        assign w_ge    = (w_trem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? 34'(w_trem - w_trial) : w_trem[33:0];
                r_root[s] <= {w_root_in[30:0], w_ge};
                r_geo[s]  <= w_geo_in;
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_geo  = r_geo[SQRT_STAGES-1];
    assign o_dist = r_root[SQRT_STAGES-1];

endmodule

// ===== hw/rtl/alsc_div.sv =====
// Pipelined restoring divider, 96 by 64 bits, quotient saturated to 32 bits.
// A range check stage, then one quotient bit per stage; depends on alsc_pkg.
module alsc_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [alsc_pkg::NUM_W-1:0]     i_num,
    input  logic [alsc_pkg::DEN_W-1:0]     i_den,
    output logic [alsc_pkg::QUO_W-1:0]     o_quo
);
    import alsc_pkg::*;

    logic             r_sat [DIV_LAT];
    logic [DEN_W-1:0] r_rem [DIV_LAT];
    logic [DEN_W-1:0] r_den [DIV_LAT];
    logic [QUO_W-1:0] r_low [DIV_LAT];
    logic [QUO_W-1:0] r_q   [DIV_LAT];

    // quotient fits only when the upper dividend is below the divisor;
    // a zero divisor saturates here too
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= (i_num[NUM_W-1:QUO_W] >= i_den);
            r_rem[0] <= i_num[NUM_W-1:QUO_W];
            r_den[0] <= i_den;
            r_low[0] <= i_num[QUO_W-1:0];
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 1; s < DIV_LAT; s++) begin : g_step
        logic [DEN_W:0] w_trem;
        logic           w_ge;

        assign w_trem = {r_rem[s-1], r_low[s-1][QUO_W-s]};
        assign w_ge   = (w_trem >= {1'b0, r_den[s-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[s] <= r_sat[s-1];
                r_rem[s] <= w_ge ? DEN_W'(w_trem - {1'b0, r_den[s-1]}) : w_trem[DEN_W-1:0];
                r_den[s] <= r_den[s-1];
                r_low[s] <= r_low[s-1];
                r_q[s]   <= {r_q[s-1][QUO_W-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_sat[DIV_LAT-1] ? '1 : r_q[DIV_LAT-1];

endmodule

// ===== hw/rtl/alsc_post.sv =====
// Shading products: cosine product, pdf divisor and radiance times area per channel.
// Four register stages feeding the final divides; depends on alsc_pkg.
module alsc_post (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic                       i_rej,
    input  logic [63:0]                i_d2,
    input  logic [31:0]                i_cx,
    input  logic [31:0]                i_cy,
    input  logic [31:0]                i_area,
    input  logic [15:0]                i_rad_r,
    input  logic [15:0]                i_rad_g,
    input  logic [15:0]                i_rad_b,
    output logic                       o_vld,
    output logic                       o_rej,
    output logic [63:0]                o_d2,
    output logic [alsc_pkg::NUM_W-1:0] o_pdf_num,
    output logic [alsc_pkg::DEN_W-1:0] o_pdf_den,
    output logic [alsc_pkg::NUM_W-1:0] o_red_num,
    output logic [alsc_pkg::NUM_W-1:0] o_green_num,
    output logic [alsc_pkg::NUM_W-1:0] o_blue_num
);
    import alsc_pkg::*;

    logic [15:0] w_rad [3];

    // stage 1
    logic [63:0] r1_prod;
    logic [63:0] r1_pden;
    logic [63:0] r1_d2;
    logic        r1_rej;
    logic        r1_vld;
    // stage 2
    logic [51:0] r2_v [3];
    logic [51:0] n2_v [3];
    logic [63:0] r2_pden;
    logic [63:0] r2_d2;
    logic        r2_rej;
    logic        r2_vld;
    // stage 3
    logic [57:0] r3_pl [3];
    logic [57:0] n3_pl [3];
    logic [57:0] r3_ph [3];
    logic [57:0] n3_ph [3];
    logic [63:0] r3_pden;
    logic [63:0] r3_d2;
    logic        r3_rej;
    logic        r3_vld;
    // stage 4
    logic [83:0]      w_sum [3];
    logic [NUM_W-1:0] r4_num [3];
    logic [NUM_W-1:0] n4_num [3];
    logic [63:0]      r4_pden;
    logic [63:0]      r4_d2;
    logic             r4_rej;
    logic             r4_vld;

    assign w_rad[0] = i_rad_r;
    assign w_rad[1] = i_rad_g;
    assign w_rad[2] = i_rad_b;

    // radiance times t, then times area in two halves
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n2_v[c]   = 52'(w_rad[c]) * 52'(r1_prod[63:28]);
            n3_pl[c]  = 58'(r2_v[c][25:0]) * 58'(i_area);
            n3_ph[c]  = 58'(r2_v[c][51:26]) * 58'(i_area);
            w_sum[c]  = (84'(r3_ph[c]) << 26) + 84'(r3_pl[c]);
            n4_num[c] = {18'b0, w_sum[c][83:6]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= 64'(i_cx) * 64'(i_cy);
            r1_pden <= 64'(i_cy) * 64'(i_area);
            r1_d2   <= i_d2;
            r1_rej  <= i_rej || (i_cx == '0) || (i_cy == '0);
            r2_v    <= n2_v;
            r2_pden <= r1_pden;
            r2_d2   <= r1_d2;
            r2_rej  <= r1_rej;
            r3_pl   <= n3_pl;
            r3_ph   <= n3_ph;
            r3_pden <= r2_pden;
            r3_d2   <= r2_d2;
            r3_rej  <= r2_rej;
            r4_num  <= n4_num;
            r4_pden <= r3_pden;
            r4_d2   <= r3_d2;
            r4_rej  <= r3_rej;
        end
    end

    assign o_vld       = r4_vld;
    assign o_rej       = r4_rej;
    assign o_d2        = r4_d2;
    assign o_pdf_num   = {2'b0, r4_d2, 30'b0};
    assign o_pdf_den   = r4_pden;
    assign o_red_num   = r4_num[0];
    assign o_green_num = r4_num[1];
    assign o_blue_num  = r4_num[2];

endmodule

// ===== dv/alsc_checker.sv =====
// Checker for the area light sample contribution block: predicts each result
// from accepted input items and its own copy of the light registers, then compares.
// Depends on alsc_pkg and the alsc_in_if / alsc_out_if channel interfaces.
module alsc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    alsc_in_if                              in_ch,
    alsc_out_if                             out_ch,
    input  logic                            i_cfg_wr_en,
    input  logic [alsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import alsc_pkg::*;

    localparam logic [31:0] SAT = 32'hFFFF_FFFF;

    // Local copy of the light registers
    logic signed [15:0] lnx, lny, lnz;
    logic [31:0]        area;
    logic [15:0]        rad_r, rad_g, rad_b;

    t_out_item contrib_q[$];

    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root, rem, trial;
        root = 0;
        rem  = 0;
        for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            root  = root << 1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = root | 64'd1;
            end
        end
        return root[31:0];
    endfunction

    function automatic logic [31:0] sat_div(logic [127:0] num, logic [63:0] den);
        logic [127:0] q;
        if (den == 0) return SAT;
        q = num / {64'd0, den};
        return (q > 128'(SAT)) ? SAT : q[31:0];
    endfunction

    // Radiance channel: rad * t * area / 2^6, then divided by the squared distance
    function automatic logic [31:0] shade(logic [15:0] rad, logic [63:0] t, logic [63:0] d2);
        logic [127:0] p;
        p = (128'(rad) * 128'(t) * 128'(area)) >> 6;
        return sat_div(p, d2);
    endfunction

    function automatic t_out_item light_contribution(t_in_item it);
        t_out_item r;
        longint dx, dy, dz, a, b;
        logic [63:0] mx, my, mz, d2, d_len, cx, cy, t, ua, ub, den;
        logic [65:0] sum;
        r  = '0;
        dx = longint'(it.light_x) - longint'(it.hit_x);
        dy = longint'(it.light_y) - longint'(it.hit_y);
        dz = longint'(it.light_z) - longint'(it.hit_z);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        mz = dz < 0 ? -dz : dz;
        sum = 66'(mx) * 66'(mx) + 66'(my) * 66'(my) + 66'(mz) * 66'(mz);
        d2 = sum[65:2];
        if (d2 == 0) return r;   // zero squared distance
        a = longint'(it.surface_normal_x) * dx + longint'(it.surface_normal_y) * dy
          + longint'(it.surface_normal_z) * dz;
        b = -(longint'(lnx) * dx + longint'(lny) * dy + longint'(lnz) * dz);
        if (a <= 0 || b <= 0) return r;   // back facing at either end
        d_len = 64'(floor_sqrt(d2));
        ua = a;
        ub = b;
        cx = (ua << 13) / d_len;
        cy = (ub << 13) / d_len;
        if (cx == 0 || cy == 0) return r;   // grazing cosine
        den = cy * 64'(area);
        r.sample_pdf    = sat_div({34'd0, d2, 30'd0}, den);
        t = (cx * cy) >> 28;
        r.contrib_red   = shade(rad_r, t, d2);
        r.contrib_green = shade(rad_g, t, d2);
        r.contrib_blue  = shade(rad_b, t, d2);
        r.sample_valid  = 1'b1;
        return r;
    endfunction

    // Register writes, prediction and comparison
    always @(posedge i_clk) begin
        t_out_item exp_r, got;
        if (!i_rst_n) begin
            lnx          <= NORMAL_X_RST;
            lny          <= NORMAL_Y_RST;
            lnz          <= NORMAL_Z_RST;
            area         <= AREA_RST;
            rad_r        <= RADIANCE_RST;
            rad_g        <= RADIANCE_RST;
            rad_b        <= RADIANCE_RST;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_NORMAL_X:   lnx   <= i_cfg_data[15:0];
                    CFG_NORMAL_Y:   lny   <= i_cfg_data[15:0];
                    CFG_NORMAL_Z:   lnz   <= i_cfg_data[15:0];
                    CFG_AREA:       area  <= i_cfg_data;
                    CFG_RADIANCE_R: rad_r <= i_cfg_data[15:0];
                    CFG_RADIANCE_G: rad_g <= i_cfg_data[15:0];
                    CFG_RADIANCE_B: rad_b <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                contrib_q.push_back(light_contribution(in_ch.payload));
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (contrib_q.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = contrib_q.pop_front();
                    if (got.contrib_red !== exp_r.contrib_red)
                        $display("%0t: contrib_red exp %h got %h", $time,
                                 exp_r.contrib_red, got.contrib_red);
                    if (got.contrib_green !== exp_r.contrib_green)
                        $display("%0t: contrib_green exp %h got %h", $time,
                                 exp_r.contrib_green, got.contrib_green);
                    if (got.contrib_blue !== exp_r.contrib_blue)
                        $display("%0t: contrib_blue exp %h got %h", $time,
                                 exp_r.contrib_blue, got.contrib_blue);
                    if (got.sample_pdf !== exp_r.sample_pdf)
                        $display("%0t: sample_pdf exp %h got %h", $time,
                                 exp_r.sample_pdf, got.sample_pdf);
                    if (got.sample_valid !== exp_r.sample_valid)
                        $display("%0t: sample_valid exp %b got %b", $time,
                                 exp_r.sample_valid, got.sample_valid);
                    if (got !== exp_r) o_fail_count <= o_fail_count + 1;
                end
            end
            // Leftover expectations count as failures once the top samples them at the end
            o_pending <= contrib_q.size();
        end
    end

endmodule

// ===== dv/tb_area_light_sample_contribution_top.sv =====
// Testbench top for area_light_sample_contribution_top: clock, reset, config
// phases, directed and random items, result back-pressure and the verdict.
// Depends on alsc_pkg, alsc_if, the block RTL and alsc_checker.
module tb_area_light_sample_contribution_top;
    import alsc_pkg::*;

    localparam int DRAIN_CYCLES = 150;   // beyond the pipeline latency
    localparam int STALL_LIMIT  = 5000;

    logic i_clk, i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int   fail_count, pending;
    int   stall_cycles;
    bit   no_idle;
    int   dirz;

    alsc_in_if  in_ch();
    alsc_out_if out_ch();

    area_light_sample_contribution_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    alsc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = (gap_len() == 0);
        end
    end

    // Watchdog on cycles with no accepted item on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(t_in_item it);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid = 0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.payload = it;
        in_ch.valid   = 1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait for every expected result, then let the pipeline empty
    task automatic drain();
        in_ch.valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_wr_en = 1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_wr_en = 0;
    endtask

    task automatic set_light(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [31:0] ar, logic [15:0] r, logic [15:0] g,
                             logic [15:0] b);
        write_reg(CFG_NORMAL_X, {16'd0, nx});
        write_reg(CFG_NORMAL_Y, {16'd0, ny});
        write_reg(CFG_NORMAL_Z, {16'd0, nz});
        write_reg(CFG_AREA, ar);
        write_reg(CFG_RADIANCE_R, {16'd0, r});
        write_reg(CFG_RADIANCE_G, {16'd0, g});
        write_reg(CFG_RADIANCE_B, {16'd0, b});
    endtask

    function automatic t_in_item mk(int hx, int hy, int hz, shortint nx, shortint ny,
                                    shortint nz, int lx, int ly, int lz);
        t_in_item it;
        it.hit_x = hx; it.hit_y = hy; it.hit_z = hz;
        it.surface_normal_x = nx; it.surface_normal_y = ny; it.surface_normal_z = nz;
        it.light_x = lx; it.light_y = ly; it.light_z = lz;
        return it;
    endfunction

    function automatic int signed_rand(int bits);
        int v;
        v = $urandom_range(0, (1 << bits) - 1);
        return $urandom_range(1) ? -v : v;
    endfunction

    // Light sits along dirz from the hit, normals roughly facing each other
    function automatic t_in_item facing_item();
        t_in_item it;
        int span, hx, hy, hz;
        span = $urandom_range(4, 24);
        if ($urandom_range(3) == 0) begin
            hx = $urandom; hy = $urandom; hz = $urandom;
        end else begin
            hx = signed_rand(26); hy = signed_rand(26); hz = signed_rand(26);
        end
        it = mk(hx, hy, hz, shortint'(signed_rand(13)), shortint'(signed_rand(13)),
                shortint'(dirz * $urandom_range(8192, 32767)),
                hx + signed_rand(span), hy + signed_rand(span),
                hz + dirz * $urandom_range(1, (1 << span) - 1));
        return it;
    endfunction

    task automatic random_phase(int count);
        t_in_item    it;
        logic [255:0] raw;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) begin
                raw = {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
                it  = raw[$bits(t_in_item)-1:0];
            end else begin
                it = facing_item();
            end
            send_item(it);
        end
        drain();
    endtask

    initial begin
        in_ch.valid   = 0;
        in_ch.payload = '0;
        i_cfg_wr_en   = 0;
        i_cfg_index   = CFG_NORMAL_X;
        i_cfg_data    = '0;
        no_idle       = 0;
        dirz          = -1;
        i_rst_n       = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed, reset config: light normal +z, so light lies below the hit
        send_item(mk(0, 0, 0, 0, 0, -16384, 0, 0, -65536));
        send_item(mk(0, 0, 0, 0, 0, -16384, 0, 0, 0));            // coincident
        send_item(mk(0, 0, 0, 0, 0, -16384, 1, 0, -1));           // d2 below 4 raw
        send_item(mk(0, 0, 0, 0, 0, 16384, 0, 0, -65536));        // surface faces away
        send_item(mk(0, 0, 0, 0, 0, -16384, 0, 0, 65536));        // behind the light
        send_item(mk(0, 0, 32'h7FFF_FFFF, 0, 0, -32768,
                     0, 0, 32'h8000_0000));                       // largest distance
        send_item(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32767, 32767, -32768,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(mk(0, 0, 0, 1, 0, 0, 1, 0, -32'h4000_0000));    // grazing cosine
        send_item(mk(0, 0, 65536, -32768, -32768, -32768, -65536, -65536, 0));
        send_item(mk(0, 0, 0, 32767, 0, -1, 65536, 0, -2));       // out of range normal
        send_item(mk(12345, -999, 77, 0, 0, -16384, 12345, -999, 70));
        send_item(mk(0, 0, 2, 0, 0, -16384, 0, 0, 0));            // smallest accepted d
        no_idle = 1;
        for (int i = 0; i < 6; i++)
            send_item(mk(0, 0, 0, shortint'(signed_rand(14)), 0, -16384,
                         signed_rand(20), signed_rand(20), -$urandom_range(1, 1 << 20)));
        no_idle = 0;
        drain();

        // Random phases across several light settings, extremes included
        dirz = 1;
        set_light(16'd0, 16'd0, -16'sd16384, 32'd65536, 16'd256, 16'd256, 16'd256);
        random_phase(220);
        set_light(16'd123, -16'sd77, 16'h8000, 32'd1, 16'hFFFF, 16'd0, 16'd1);
        no_idle = 1;
        random_phase(200);
        no_idle = 0;
        dirz = -1;
        set_light(16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(200);
        set_light(16'd0, 16'd0, 16'd16384, 32'd0, 16'd4096, 16'd4096, 16'd4096);  // zero area
        random_phase(150);
        dirz = 1;
        set_light(-16'sd5000, 16'd3000, -16'sd20000, $urandom, 16'($urandom),
                  16'($urandom), 16'($urandom));
        random_phase(220);
        set_light(16'd0, 16'd0, -16'sd16384, $urandom_range(1, 1 << 20), 16'($urandom),
                  16'($urandom), 16'($urandom));
        random_phase(240);

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
